FILE: rtl/json_string_escaper_utf8_check_defines.svh
// assertion macros for the json string escaper
`ifndef JSON_STRING_ESCAPER_UTF8_CHECK_DEFINES_SVH
`define JSON_STRING_ESCAPER_UTF8_CHECK_DEFINES_SVH

`ifndef SYNTHESIS
`define JSE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define JSE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`else
`define JSE_ASSERT(lbl, prop, msg)
`define JSE_ASSERT_IMP(lbl, ante, cons, msg)
`endif

`endif

FILE: rtl/jse_pkg.sv
package jse_pkg;

  typedef enum logic [2:0] {
    FK_NONE,
    FK_PLAIN,
    FK_ESC2,
    FK_U6,
    FK_INVAL
  } fkind_t;

  typedef enum logic [2:0] {
    PH_OPEN,
    PH_PRE,
    PH_FRESH,
    PH_POST,
    PH_CLOSE
  } phase_t;

  typedef struct packed {
    logic            open_q;
    logic            pre_raw;
    logic [1:0]      pre_cnt;
    logic [2:0][7:0] pre_bytes;
    fkind_t          fkind;
    logic [7:0]      fbyte;
    logic [7:0]      fesc;
    logic [1:0]      post_cnt;
    logic [2:0][7:0] post_bytes;
    logic            close_q;
  } job_t;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_ZERO   = 8'h30;

endpackage

FILE: rtl/json_string_escaper_utf8_check.sv
// JSON string escaper with UTF-8 checking.
// Input channel (in_valid/in_ready): one string byte per item, or none when
// in_has_byte is low; in_chunk_end marks the last item of a chunk and, with
// in_string_done, closes the string with a quote. The opening quote comes
// out ahead of the first item that finds no string open.
// Output channel (out_valid/out_ready): one escaped byte per item;
// out_run_last marks the last byte caused by one input item. Items that
// cause no byte (a held UTF-8 continuation) produce nothing.
// Config channel (cfg_valid/cfg_ready): cfg_escape_invalid, 1 after reset;
// write only while idle. cfg_ready is always high.
// An item goes into the 2-entry job queue, which lets the front keep taking
// items, then into the expander's job register; output bytes are registered.
// Throughput: one output byte per cycle while out_ready is high and a job
// waits, set by the single output byte lane of the expander, which an item
// holds until its last byte is out. in_ready drops while the queue is full.
// Reset (rst_n low, synchronous) empties the queue and output register and
// closes any open string. A stalled receiver holds the output byte and,
// once the queue fills, stalls the input.
module json_string_escaper_utf8_check import jse_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_has_byte,
  input  logic [7:0] in_byte_value,
  input  logic       in_chunk_end,
  input  logic       in_string_done,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_run_last,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_escape_invalid
);

  logic esc_inv_r;
  logic push_valid;
  job_t push_job;
  logic pop;
  job_t head;
  logic fifo_full;
  logic fifo_empty;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esc_inv_r <= 1'b1;
    end else if (cfg_valid) begin
      esc_inv_r <= cfg_escape_invalid;
    end
  end

  jse_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_has_byte    (in_has_byte),
    .in_byte_value  (in_byte_value),
    .in_chunk_end   (in_chunk_end),
    .in_string_done (in_string_done),
    .escape_invalid (esc_inv_r),
    .fifo_full      (fifo_full),
    .push_valid     (push_valid),
    .push_job       (push_job)
  );

  jse_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push_valid),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .full     (fifo_full),
    .empty    (fifo_empty)
  );

  jse_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head         (head),
    .fifo_empty   (fifo_empty),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .out_run_last (out_run_last)
  );

endmodule

FILE: rtl/jse_front.sv
`include "json_string_escaper_utf8_check_defines.svh"

module jse_front import jse_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_has_byte,
  input  logic [7:0] in_byte_value,
  input  logic       in_chunk_end,
  input  logic       in_string_done,
  input  logic       escape_invalid,
  input  logic       fifo_full,
  output logic       push_valid,
  output job_t       push_job
);

  localparam logic [7:0] C_BS = 8'h08;
  localparam logic [7:0] C_HT = 8'h09;
  localparam logic [7:0] C_LF = 8'h0a;
  localparam logic [7:0] C_VT = 8'h0b;
  localparam logic [7:0] C_FF = 8'h0c;
  localparam logic [7:0] C_CR = 8'h0d;
  localparam logic [7:0] CH_B = 8'h62;
  localparam logic [7:0] CH_T = 8'h74;
  localparam logic [7:0] CH_N = 8'h6e;
  localparam logic [7:0] CH_V = 8'h76;
  localparam logic [7:0] CH_F = 8'h66;
  localparam logic [7:0] CH_R = 8'h72;
  localparam logic [7:0] CTRL_LIMIT = 8'h20;

  typedef struct packed {
    fkind_t     kind;
    logic [7:0] esc;
    logic       hold;
    logic [2:0] len;
  } fcls_t;

  function automatic fcls_t classify(input logic [7:0] b);
    fcls_t c;
    c.kind = FK_NONE;
    c.esc  = 8'h00;
    c.hold = 1'b0;
    c.len  = 3'd0;
    case (b)
      CH_BSLASH: c.esc = CH_BSLASH;
      CH_QUOTE:  c.esc = CH_QUOTE;
      C_LF:      c.esc = CH_N;
      C_BS:      c.esc = CH_B;
      C_HT:      c.esc = CH_T;
      C_VT:      c.esc = CH_V;
      C_FF:      c.esc = CH_F;
      C_CR:      c.esc = CH_R;
      default:   c.esc = 8'h00;
    endcase
    if (c.esc != 8'h00) begin
      c.kind = FK_ESC2;
    end else if (b < CTRL_LIMIT) begin
      c.kind = FK_U6;
    end else if (!b[7]) begin
      c.kind = FK_PLAIN;
    end else if (b[7:6] == 2'b10) begin
      c.kind = FK_INVAL;
    end else if (b[7:5] == 3'b110) begin
      if (b[7:1] == 7'b1100000) begin
        c.kind = FK_INVAL;
      end else begin
        c.hold = 1'b1;
        c.len  = 3'd2;
      end
    end else if (b[7:4] == 4'b1110) begin
      c.hold = 1'b1;
      c.len  = 3'd3;
    end else if (b[7:3] == 5'b11110) begin
      if (b[2:0] >= 3'd5) begin
        c.kind = FK_INVAL;
      end else begin
        c.hold = 1'b1;
        c.len  = 3'd4;
      end
    end else begin
      c.kind = FK_INVAL;
    end
    return c;
  endfunction

  logic            open_r, open_nxt;
  logic [2:0][7:0] held_r, held_nxt;
  logic [1:0]      hcnt_r, hcnt_nxt;
  logic [2:0]      slen_r, slen_nxt;
  logic            acc;
  logic            use_cls;
  fcls_t           cls;
  job_t            job;

  assign in_ready = !fifo_full;
  assign acc      = in_valid && !fifo_full;

  always_comb begin
    job       = '0;
    held_nxt  = held_r;
    hcnt_nxt  = hcnt_r;
    slen_nxt  = slen_r;
    use_cls   = 1'b0;
    cls       = classify(in_byte_value);
    job.open_q    = !open_r;
    open_nxt      = 1'b1;
    job.fbyte     = in_byte_value;
    job.fesc      = cls.esc;
    job.pre_bytes = held_r;
    if (in_has_byte) begin
      if (hcnt_r == 2'd0) begin
        use_cls = 1'b1;
      end else if (in_byte_value[7:6] == 2'b10) begin
        if (((3'(hcnt_r) + 3'd1) >= slen_r) || (hcnt_r == 2'd3)) begin
          job.pre_raw = 1'b1;
          job.pre_cnt = hcnt_r;
          job.fkind   = FK_PLAIN;
          hcnt_nxt    = 2'd0;
          slen_nxt    = 3'd0;
        end else begin
          held_nxt[hcnt_r] = in_byte_value;
          hcnt_nxt         = hcnt_r + 2'd1;
        end
      end else begin
        // broken sequence: held bytes are invalid, new byte starts over
        job.pre_cnt = escape_invalid ? hcnt_r : 2'd0;
        hcnt_nxt    = 2'd0;
        slen_nxt    = 3'd0;
        use_cls     = 1'b1;
      end
      if (use_cls) begin
        if (cls.hold) begin
          held_nxt[0] = in_byte_value;
          hcnt_nxt    = 2'd1;
          slen_nxt    = cls.len;
        end else if (cls.kind == FK_INVAL && !escape_invalid) begin
          job.fkind = FK_NONE;
        end else begin
          job.fkind = cls.kind;
        end
      end
    end
    if (in_chunk_end) begin
      job.post_cnt   = hcnt_nxt;
      job.post_bytes = held_nxt;
      hcnt_nxt       = 2'd0;
      slen_nxt       = 3'd0;
      job.close_q    = in_string_done;
      open_nxt       = !in_string_done;
    end
  end

  assign push_job   = job;
  assign push_valid = acc && (job.open_q || job.pre_cnt != 2'd0 || job.fkind != FK_NONE ||
                              job.post_cnt != 2'd0 || job.close_q);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r <= 1'b0;
      hcnt_r <= 2'd0;
      slen_r <= 3'd0;
    end else if (acc) begin
      open_r <= open_nxt;
      hcnt_r <= hcnt_nxt;
      slen_r <= slen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      held_r <= held_nxt;
    end
  end

  `JSE_ASSERT_IMP(a_held_fits, hcnt_r != 2'd0, hcnt_r < slen_r, "held count exceeds sequence")

endmodule

FILE: rtl/jse_fifo.sv
`include "json_string_escaper_utf8_check_defines.svh"

module jse_fifo import jse_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output job_t head,
  output logic full,
  output logic empty
);

  localparam int DEPTH = 2;

  job_t       mem_r [DEPTH];
  logic       wp_r;
  logic       rp_r;
  logic [1:0] cnt_r;

  assign full  = (cnt_r == 2'(DEPTH));
  assign empty = (cnt_r == 2'd0);
  assign head  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= !wp_r;
      end
      if (pop) begin
        rp_r <= !rp_r;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_job;
    end
  end

  `JSE_ASSERT(a_cnt_range, cnt_r <= 2'(DEPTH), "queue count out of range")
  `JSE_ASSERT_IMP(a_no_underflow, pop, !empty, "pop from empty queue")
  `JSE_ASSERT_IMP(a_no_overflow, push, !full, "push into full queue")

endmodule

FILE: rtl/jse_back.sv
`include "json_string_escaper_utf8_check_defines.svh"

module jse_back import jse_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  job_t       head,
  input  logic       fifo_empty,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_run_last
);

  typedef struct packed {
    logic   ok;
    phase_t ph;
  } phsel_t;

  function automatic phsel_t first_ph(input job_t j, input phase_t from);
    phsel_t s;
    s.ok = 1'b1;
    s.ph = PH_CLOSE;
    if (from == PH_OPEN && j.open_q) begin
      s.ph = PH_OPEN;
    end else if (from <= PH_PRE && j.pre_cnt != 2'd0) begin
      s.ph = PH_PRE;
    end else if (from <= PH_FRESH && j.fkind != FK_NONE) begin
      s.ph = PH_FRESH;
    end else if (from <= PH_POST && j.post_cnt != 2'd0) begin
      s.ph = PH_POST;
    end else if (j.close_q) begin
      s.ph = PH_CLOSE;
    end else begin
      s.ok = 1'b0;
    end
    return s;
  endfunction

  function automatic logic [7:0] hex_digit(input logic [3:0] n);
    return (n < 4'd10) ? (8'h30 + 8'(n)) : (8'h57 + 8'(n));
  endfunction

  job_t       job_r;
  logic       job_v_r;
  phase_t     ph_r, ph_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic [2:0] sub_r, sub_nxt;
  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       out_last_r;

  logic       adv;
  logic       last;
  logic       stay;
  logic       has_after;
  phase_t     after;
  phsel_t     sel;
  phsel_t     hsel;
  logic [2:0] pre_max;
  logic [2:0] fresh_max;
  logic [7:0] cur_byte;
  logic [7:0] hb;

  assign adv  = job_v_r && (!out_valid_r || out_ready);
  assign pop  = (!job_v_r || (adv && last)) && !fifo_empty;
  assign hsel = first_ph(head, PH_OPEN);

  assign pre_max = job_r.pre_raw ? 3'd0 : 3'd3;

  always_comb begin
    case (job_r.fkind)
      FK_ESC2:  fresh_max = 3'd1;
      FK_U6:    fresh_max = 3'd5;
      FK_INVAL: fresh_max = 3'd3;
      default:  fresh_max = 3'd0;
    endcase
  end

  // next position within the current job
  always_comb begin
    ph_nxt    = ph_r;
    idx_nxt   = idx_r;
    sub_nxt   = sub_r;
    stay      = 1'b0;
    has_after = 1'b1;
    after     = PH_CLOSE;
    last      = 1'b0;
    sel       = '0;
    unique case (ph_r)
      PH_OPEN: begin
        after = PH_PRE;
      end
      PH_PRE: begin
        after = PH_FRESH;
        if (sub_r < pre_max) begin
          sub_nxt = sub_r + 3'd1;
          stay    = 1'b1;
        end else if ((3'(idx_r) + 3'd1) < 3'(job_r.pre_cnt)) begin
          idx_nxt = idx_r + 2'd1;
          sub_nxt = 3'd0;
          stay    = 1'b1;
        end
      end
      PH_FRESH: begin
        after = PH_POST;
        if (sub_r < fresh_max) begin
          sub_nxt = sub_r + 3'd1;
          stay    = 1'b1;
        end
      end
      PH_POST: begin
        after = PH_CLOSE;
        if ((3'(idx_r) + 3'd1) < 3'(job_r.post_cnt)) begin
          idx_nxt = idx_r + 2'd1;
          stay    = 1'b1;
        end
      end
      PH_CLOSE: begin
        has_after = 1'b0;
      end
      default: begin
        has_after = 1'b0;
      end
    endcase
    if (!stay) begin
      if (has_after) begin
        sel = first_ph(job_r, after);
      end
      if (sel.ok) begin
        ph_nxt  = sel.ph;
        idx_nxt = 2'd0;
        sub_nxt = 3'd0;
      end else begin
        last = 1'b1;
      end
    end
  end

  // byte at the current position
  always_comb begin
    hb       = job_r.pre_bytes[idx_r];
    cur_byte = CH_QUOTE;
    unique case (ph_r)
      PH_OPEN, PH_CLOSE: begin
        cur_byte = CH_QUOTE;
      end
      PH_PRE: begin
        if (job_r.pre_raw) begin
          cur_byte = hb;
        end else begin
          case (sub_r)
            3'd0:    cur_byte = CH_BSLASH;
            3'd1:    cur_byte = CH_X;
            3'd2:    cur_byte = hex_digit(hb[7:4]);
            default: cur_byte = hex_digit(hb[3:0]);
          endcase
        end
      end
      PH_FRESH: begin
        unique case (job_r.fkind)
          FK_ESC2: begin
            cur_byte = (sub_r == 3'd0) ? CH_BSLASH : job_r.fesc;
          end
          FK_U6: begin
            case (sub_r)
              3'd0:       cur_byte = CH_BSLASH;
              3'd1:       cur_byte = CH_U;
              3'd2, 3'd3: cur_byte = CH_ZERO;
              3'd4:       cur_byte = hex_digit(job_r.fbyte[7:4]);
              default:    cur_byte = hex_digit(job_r.fbyte[3:0]);
            endcase
          end
          FK_INVAL: begin
            case (sub_r)
              3'd0:    cur_byte = CH_BSLASH;
              3'd1:    cur_byte = CH_X;
              3'd2:    cur_byte = hex_digit(job_r.fbyte[7:4]);
              default: cur_byte = hex_digit(job_r.fbyte[3:0]);
            endcase
          end
          default: begin
            cur_byte = job_r.fbyte;
          end
        endcase
      end
      PH_POST: begin
        cur_byte = job_r.post_bytes[idx_r];
      end
      default: begin
        cur_byte = CH_QUOTE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_v_r <= 1'b0;
      ph_r    <= PH_OPEN;
      idx_r   <= 2'd0;
      sub_r   <= 3'd0;
    end else if (pop) begin
      job_v_r <= 1'b1;
      ph_r    <= hsel.ph;
      idx_r   <= 2'd0;
      sub_r   <= 3'd0;
    end else if (adv && last) begin
      job_v_r <= 1'b0;
    end else if (adv) begin
      ph_r  <= ph_nxt;
      idx_r <= idx_nxt;
      sub_r <= sub_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      job_r <= head;
    end
    if (adv) begin
      out_byte_r <= cur_byte;
      out_last_r <= last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_byte     = out_byte_r;
  assign out_run_last = out_last_r;

  `JSE_ASSERT_IMP(a_pre_idx, job_v_r && ph_r == PH_PRE, idx_r < job_r.pre_cnt, "bad pre index")
  `JSE_ASSERT_IMP(a_post_idx, job_v_r && ph_r == PH_POST, idx_r < job_r.post_cnt, "bad post index")

endmodule

FILE: tb/json_string_escaper_utf8_check_tb.sv
module json_string_escaper_utf8_check_tb;
  import jse_pkg::*;

  typedef struct {
    logic [7:0] ch;
    logic       last;
  } text_byte_t;

  localparam logic [7:0] ESC_CHARS [8] = '{8'h0a, 8'h08, 8'h09, 8'h0b, 8'h0c, 8'h0d,
                                           8'h5c, 8'h22};
  localparam int IDLE_CYCLES = 8;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic       in_has_byte;
  logic [7:0] in_byte_value;
  logic       in_chunk_end;
  logic       in_string_done;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic       out_run_last;
  logic       cfg_valid;
  logic       cfg_ready;
  logic       cfg_escape_invalid;

  // escaper state as predicted
  bit         esc_invalid;
  bit         str_open;
  logic [7:0] held [3];
  int         held_cnt;
  int         seq_len;

  logic [7:0] item_text [$];
  text_byte_t expected_text [$];

  int errors = 0;
  int items_sent = 0;
  int stall_pct = 0;
  int gap_pct = 0;
  int stall_left = 0;

  json_string_escaper_utf8_check DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_has_byte        (in_has_byte),
    .in_byte_value      (in_byte_value),
    .in_chunk_end       (in_chunk_end),
    .in_string_done     (in_string_done),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_byte           (out_byte),
    .out_run_last       (out_run_last),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_escape_invalid (cfg_escape_invalid)
  );

  always #4 clk = ~clk;

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    return (n < 4'd10) ? 8'h30 + 8'(n) : 8'h57 + 8'(n);
  endfunction

  function automatic void put_text(input logic [7:0] c);
    if (item_text.size() < 20) item_text.push_back(c);
  endfunction

  function automatic void put_invalid(input logic [7:0] b);
    if (esc_invalid) begin
      put_text(CH_BSLASH);
      put_text(CH_X);
      put_text(hex_char(b[7:4]));
      put_text(hex_char(b[3:0]));
    end
  endfunction

  function automatic void flush_held();
    for (int i = 0; i < held_cnt; i++) put_text(held[i]);
    held_cnt = 0;
    seq_len = 0;
  endfunction

  function automatic void hold_lead(input logic [7:0] b, input int n);
    held[0] = b;
    held_cnt = 1;
    seq_len = n;
  endfunction

  function automatic void escape_fresh(input logic [7:0] b);
    logic [7:0] esc;
    case (b)
      8'h5c: esc = CH_BSLASH;
      8'h22: esc = CH_QUOTE;
      8'h0a: esc = "n";
      8'h08: esc = "b";
      8'h09: esc = "t";
      8'h0b: esc = "v";
      8'h0c: esc = "f";
      8'h0d: esc = "r";
      default: esc = 8'h00;
    endcase
    if (esc != 8'h00) begin
      put_text(CH_BSLASH);
      put_text(esc);
    end else if (b < 8'h20) begin
      put_text(CH_BSLASH);
      put_text(CH_U);
      put_text(CH_ZERO);
      put_text(CH_ZERO);
      put_text(hex_char(b[7:4]));
      put_text(hex_char(b[3:0]));
    end else if (!b[7]) begin
      put_text(b);
    end else if (b[7:6] == 2'b10) begin
      put_invalid(b);
    end else if (b[7:5] == 3'b110) begin
      if (b == 8'hc0 || b == 8'hc1) put_invalid(b);
      else hold_lead(b, 2);
    end else if (b[7:4] == 4'he) begin
      hold_lead(b, 3);
    end else if (b[7:3] == 5'b11110) begin
      if (b[2:0] >= 3'd5) put_invalid(b);
      else hold_lead(b, 4);
    end else begin
      put_invalid(b);
    end
  endfunction

  function automatic void take_byte(input logic [7:0] b);
    if (held_cnt == 0) begin
      escape_fresh(b);
    end else if (b[7:6] == 2'b10) begin
      if (held_cnt + 1 >= seq_len || held_cnt >= 3) begin
        flush_held();
        put_text(b);
      end else begin
        held[held_cnt] = b;
        held_cnt++;
      end
    end else begin
      for (int i = 0; i < held_cnt; i++) put_invalid(held[i]);
      held_cnt = 0;
      seq_len = 0;
      escape_fresh(b);
    end
  endfunction

  function automatic void predict_item(input logic has, input logic [7:0] b,
                                       input logic ce, input logic sd);
    item_text.delete();
    if (!str_open) begin
      put_text(CH_QUOTE);
      str_open = 1'b1;
    end
    if (has) take_byte(b);
    if (ce) begin
      flush_held();
      if (sd) put_text(CH_QUOTE);
      str_open = !sd;
    end
    foreach (item_text[i])
      expected_text.push_back('{ch: item_text[i], last: (i == item_text.size() - 1)});
  endfunction

  // output side: random stall bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      out_ready <= 1'b0;
      stall_left <= $urandom_range(0, 3);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    text_byte_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_text.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected output byte %h run_last %b", out_byte, out_run_last);
      end else begin
        want = expected_text.pop_front();
        if (out_byte !== want.ch || out_run_last !== want.last) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected byte %h run_last %b, got byte %h run_last %b",
                     want.ch, want.last, out_byte, out_run_last);
        end
      end
    end
  end

  task automatic send_item(input logic has, input logic [7:0] b, input logic ce,
                           input logic sd);
    if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_has_byte <= has;
    in_byte_value <= b;
    in_chunk_end <= ce;
    in_string_done <= sd;
    do @(posedge clk); while (!in_ready);
    predict_item(has, b, ce, sd);
    items_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_text.size() != 0) @(posedge clk);
    repeat (IDLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_escape_invalid(input bit v);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_escape_invalid <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    esc_invalid = v;
  endtask

  function automatic logic [7:0] lead_for(input int n);
    case (n)
      2: return 8'($urandom_range(8'hc2, 8'hdf));
      3: return 8'($urandom_range(8'he0, 8'hef));
      default: return 8'($urandom_range(8'hf0, 8'hf4));
    endcase
  endfunction

  // one random piece of text: mostly well-formed, some broken utf-8
  task automatic send_token();
    logic [7:0] seq [$];
    logic [7:0] b;
    int kind;
    int n;
    int r;
    kind = $urandom_range(0, 99);
    if ($urandom_range(0, 11) == 0)
      send_item(1'b0, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)));
    if (kind < 35) begin
      seq.push_back(8'($urandom_range(8'h20, 8'h7f)));
    end else if (kind < 45) begin
      seq.push_back(ESC_CHARS[$urandom_range(0, 7)]);
    end else if (kind < 52) begin
      seq.push_back(8'($urandom_range(0, 8'h1f)));
    end else if (kind < 80 || (kind >= 90 && kind < 97)) begin
      n = $urandom_range(2, 4);
      seq.push_back(lead_for(n));
      repeat ((kind < 80) ? n - 1 : $urandom_range(0, n - 2))
        seq.push_back(8'h80 | 8'($urandom_range(0, 8'h3f)));
      if (kind >= 90) begin
        b = 8'($urandom_range(0, 255));
        while (b[7:6] == 2'b10) b = 8'($urandom_range(0, 255));
        seq.push_back(b);
      end
    end else if (kind < 85) begin
      r = $urandom_range(0, 12);
      seq.push_back((r < 2) ? 8'hc0 + 8'(r) : 8'hf5 + 8'(r - 2));
    end else if (kind < 90) begin
      seq.push_back(8'($urandom_range(8'h80, 8'hbf)));
    end else begin
      seq.push_back(8'($urandom_range(0, 255)));
    end
    foreach (seq[i])
      send_item(1'b1, seq[i],
                (i == seq.size() - 1) ? ($urandom_range(0, 5) == 0)
                                      : ($urandom_range(0, 11) == 0),
                1'($urandom_range(0, 1)));
  endtask

  task automatic send_random_text(input int n);
    int start;
    start = items_sent;
    while (items_sent - start < n) send_token();
  endtask

  task automatic test_escapes();
    send_item(1'b1, CH_BSLASH, 1'b0, 1'b0);
    send_item(1'b1, CH_QUOTE, 1'b0, 1'b0);
    foreach (ESC_CHARS[i])
      if (i < 6) send_item(1'b1, ESC_CHARS[i], 1'b0, 1'b0);
    send_item(1'b1, 8'h00, 1'b0, 1'b0);
    send_item(1'b1, 8'h1f, 1'b0, 1'b0);
    send_item(1'b1, 8'h7f, 1'b0, 1'b0);
    // string_done alone does not close
    send_item(1'b1, 8'h7e, 1'b0, 1'b1);
    send_item(1'b0, 8'hff, 1'b1, 1'b1);
    send_item(1'b0, 8'h00, 1'b1, 1'b0);
  endtask

  task automatic test_utf8();
    send_item(1'b1, 8'hc2, 1'b0, 1'b0);
    send_item(1'b1, 8'ha9, 1'b0, 1'b0);
    send_item(1'b1, 8'hf4, 1'b0, 1'b0);
    send_item(1'b1, 8'h8f, 1'b0, 1'b0);
    send_item(1'b1, 8'hbf, 1'b0, 1'b0);
    send_item(1'b1, 8'hbf, 1'b0, 1'b0);
    // cut short at chunk end
    send_item(1'b1, 8'he2, 1'b0, 1'b0);
    send_item(1'b1, 8'h82, 1'b1, 1'b0);
    // non-continuation byte after a held continuation
    send_item(1'b1, 8'hf0, 1'b0, 1'b0);
    send_item(1'b1, 8'h90, 1'b0, 1'b0);
    send_item(1'b1, 8'h41, 1'b0, 1'b0);
    send_item(1'b1, 8'he0, 1'b0, 1'b0);
    send_item(1'b1, 8'h0a, 1'b0, 1'b0);
    send_item(1'b1, 8'hc0, 1'b0, 1'b0);
    send_item(1'b1, 8'hc1, 1'b0, 1'b0);
    send_item(1'b1, 8'hf5, 1'b0, 1'b0);
    send_item(1'b1, 8'hff, 1'b0, 1'b0);
    send_item(1'b1, 8'h80, 1'b0, 1'b0);
    send_item(1'b1, 8'hd0, 1'b0, 1'b0);
    send_item(1'b0, 8'h00, 1'b1, 1'b1);
  endtask

  task automatic test_drop_invalid();
    set_escape_invalid(1'b0);
    gap_pct = 10;
    stall_pct = 30;
    send_random_text(80);
  endtask

  task automatic test_output_stall();
    set_escape_invalid(1'b1);
    gap_pct = 0;
    stall_pct = 50;
    send_random_text(30);
    wait_drained();
    send_random_text(30);
  endtask

  task automatic test_random_mix();
    set_escape_invalid(1'b0);
    gap_pct = 25;
    stall_pct = 15;
    send_random_text(50);
    set_escape_invalid(1'b1);
    send_random_text(50);
  endtask

  task automatic test_full_rate();
    gap_pct = 0;
    stall_pct = 0;
    send_random_text(60);
  endtask

  initial begin
    int guard;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_has_byte <= 1'b0;
    in_byte_value <= 8'h00;
    in_chunk_end <= 1'b0;
    in_string_done <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_escape_invalid <= 1'b1;
    esc_invalid = 1'b1;
    str_open = 1'b0;
    held_cnt = 0;
    seq_len = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_escape_invalid(1'b1);
    gap_pct = 20;
    stall_pct = 20;
    test_escapes();
    test_utf8();
    test_drop_invalid();
    test_output_stall();
    test_random_mix();
    test_full_rate();

    in_valid <= 1'b0;
    guard = 0;
    while (expected_text.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (20) @(posedge clk);
    if (errors == 0 && expected_text.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  initial begin
    #3000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
